>>> sv/ghi_pkg.sv
`default_nettype none

package ghi_pkg;

  // field widths
  localparam int RATE_W = 16;
  localparam int TIME_W = 32;
  localparam int ACC_W  = 64;
  localparam int DB_W   = 16;

  // defaults
  localparam int CALIB_COUNT_DEF = 512;
  localparam logic [DB_W-1:0] DEADBAND_RESET = 16'd132;

  // accumulator limits
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

endpackage

`default_nettype wire

>>> sv/gyro_heading_integrator.sv
`default_nettype none

// gyro heading integrator
// input channel (in_valid / in_stall): one beat carries a raw signed z-rate
// sample and its microsecond timestamp. output channel (out_valid /
// out_stall): one beat per input beat, carrying the heading accumulator after
// that sample plus the calibrating / applied / saturated flags.
// configuration channel (cfg_valid / cfg_ready): one beat writes the dead band;
// cfg_ready is always high, write only while the block is idle.
// the first CALIB_COUNT samples after reset only build the bias sum; after that
// samples below the dead band are dropped, the first kept one only records its
// time and each later kept one adds (rate*CALIB_COUNT - bias)*dt to the
// saturating 64-bit accumulator.
// an accepted input beat passes through the product stage, then the output register.
// throughput: one beat per cycle unless the output stalls, set by the single accumulator
// add and clamp feeding back on itself; the product is formed in the stage before it.
// reset (rst, synchronous) clears the calibration, time and accumulator state,
// empties both stages and restores the dead band to its default.
// when the receiver stalls the output holds its beat; the stage behind it
// still takes one more beat, then in_stall rises until the output drains.

module gyro_heading_integrator
  import ghi_pkg::*;
#(
  parameter int CALIB_COUNT = CALIB_COUNT_DEF
) (
  input  wire                       clk,
  input  wire                       rst,
  // configuration
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire  [DB_W-1:0]           deadband_raw,
  // input beats
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire  signed [RATE_W-1:0]  rate_sample,
  input  wire  [TIME_W-1:0]         time_us,
  // output beats
  output logic                      out_valid,
  input  wire                       out_stall,
  output logic signed [ACC_W-1:0]   heading_total,
  output logic                      calibrating,
  output logic                      applied,
  output logic                      saturated
);

  // count width holds CALIB_COUNT itself, bias sum holds CALIB_COUNT samples
  localparam int CNT_W   = $clog2(CALIB_COUNT + 1);
  localparam int BIAS_W  = $clog2(CALIB_COUNT) + RATE_W;
  localparam int CORR_W  = BIAS_W + 1;
  localparam int DELTA_W = CORR_W + TIME_W + 1;
  localparam logic [CNT_W-1:0]         CALIB_N = CNT_W'(CALIB_COUNT);
  localparam logic signed [CORR_W-1:0] CALIB_S = CORR_W'(CALIB_COUNT);

  // configuration register
  logic [DB_W-1:0] deadband;

  // front state, updated as each beat is accepted
  logic [CNT_W-1:0]         calib_seen;
  logic signed [BIAS_W-1:0] bias_sum;
  logic                     time_known;
  logic [TIME_W-1:0]        last_kept_time;

  // product stage
  logic                      s1_valid;
  logic signed [DELTA_W-1:0] s1_delta;
  logic                      s1_calib;
  logic                      s1_applied;

  // accumulator, which is also the output payload
  logic signed [ACC_W-1:0] heading_acc;

  // handshakes
  logic out_load;
  logic in_acc;

  // front decision
  logic                      in_calib;
  logic                      in_kept;
  logic                      in_apply;
  logic [RATE_W:0]           rate_mag;
  logic signed [RATE_W:0]    rate_wide;
  logic [TIME_W-1:0]         dt;
  logic signed [CORR_W-1:0]  corr;
  logic signed [DELTA_W-1:0] delta_next;

  // accumulate and clamp
  logic signed [ACC_W:0]   acc_sum;
  logic                    acc_ovf;
  logic signed [ACC_W-1:0] heading_acc_next;
  logic                    saturated_next;

  assign cfg_ready = 1'b1;

  // output register loads whenever the product stage holds a beat and it is empty or being taken
  assign out_load = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !out_load;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    rate_wide = (RATE_W+1)'(rate_sample);
    rate_mag  = rate_wide[RATE_W] ? (RATE_W+1)'(-rate_wide) : rate_wide;
    in_calib  = calib_seen < CALIB_N;
    in_kept   = !in_calib && (rate_mag >= {1'b0, deadband});
    in_apply  = in_kept && time_known;
    dt        = time_us - last_kept_time;
    // bias-corrected rate, scaled by the calibration count
    corr       = CORR_W'(rate_sample) * CALIB_S - CORR_W'(bias_sum);
    delta_next = DELTA_W'(corr) * $signed({1'b0, dt});
  end

  always_comb begin
    acc_sum = (ACC_W+1)'(heading_acc) + (ACC_W+1)'(s1_delta);
    acc_ovf = acc_sum[ACC_W] != acc_sum[ACC_W-1];
    heading_acc_next = heading_acc;
    saturated_next   = 1'b0;
    if (s1_applied) begin
      if (acc_ovf) begin
        heading_acc_next = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
        saturated_next   = 1'b1;
      end else begin
        heading_acc_next = acc_sum[ACC_W-1:0];
      end
    end
  end

  // config and front state
  always_ff @(posedge clk) begin
    if (rst) begin
      deadband       <= DEADBAND_RESET;
      calib_seen     <= '0;
      bias_sum       <= '0;
      time_known     <= 1'b0;
      last_kept_time <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        deadband <= deadband_raw;
      end
      if (in_acc) begin
        if (in_calib) begin
          calib_seen <= calib_seen + 1'b1;
          bias_sum   <= bias_sum + BIAS_W'(rate_sample);
        end else if (in_kept) begin
          time_known     <= 1'b1;
          last_kept_time <= time_us;
        end
      end
    end
  end

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_delta   <= delta_next;
      s1_calib   <= in_calib;
      s1_applied <= in_apply;
    end
  end

  // accumulator and output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      heading_acc <= '0;
    end else begin
      if (out_load) begin
        out_valid   <= 1'b1;
        heading_acc <= heading_acc_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      calibrating <= s1_calib;
      applied     <= s1_applied;
      saturated   <= saturated_next;
    end
  end

  assign heading_total = heading_acc;

`ifndef SYNTHESIS
  // calibration count never runs past its limit
  a_calib_bound: assert property (@(posedge clk) disable iff (rst)
    calib_seen <= CALIB_N)
    else $error("calibration count past limit");

  // a calibration beat never touches the accumulator
  a_calib_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && calibrating |-> !applied && !saturated)
    else $error("calibration beat flagged as applied");

  // a clamp always lands on one of the limits
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> applied && (heading_acc == ACC_MAX || heading_acc == ACC_MIN))
    else $error("saturated beat not at a limit");

  // integration needs a recorded time
  a_apply_time: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_applied |-> time_known && !s1_calib)
    else $error("integration without a recorded time");

  // accumulator only moves when a beat enters the output register
  a_acc_hold: assert property (@(posedge clk) disable iff (rst)
    !out_load |=> $stable(heading_acc))
    else $error("accumulator changed without a beat");
`endif

endmodule

`default_nettype wire
